FILE: hdl/gpt_pkg.sv
// Shared types and constants for the grace period tracker.
// No dependencies; used by every module of the block.
package gpt_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ADV  = 2'd0,
        CMD_NOTE = 2'd1,
        CMD_ENQ  = 2'd2,
        CMD_REL  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_ram_ctl;

    localparam int          CMD_W          = 2;
    localparam int          CPU_W          = 4;
    localparam int          ACT_W          = 5;
    localparam int          SEQ_W          = 32;
    localparam int          MASK_OUT_W     = 16;
    localparam int          REL_OUT_W      = 16;
    localparam int          APB_AW         = 3;
    localparam int          APB_DW         = 32;
    localparam logic        REG_ACTIVE     = 1'b0;
    localparam logic [4:0]  ACTIVE_RESET   = 5'd16;

endpackage

FILE: hdl/gpt_cnt_ram.sv
// Counter memory: one write and one read port, registered read data.
// Per-entry non-zero flags make unwritten or cleared entries read as zero.
// Depends on gpt_pkg.
module gpt_cnt_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gpt_pkg::t_ram_ctl   i_ctl,
    input  logic [AW-1:0]       i_raddr,
    input  logic [AW-1:0]       i_waddr,
    input  logic [DW-1:0]       i_wdata,
    output logic [DW-1:0]       o_rdata,
    output logic [DEPTH-1:0]    o_nz
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_data;
    logic             r_flag;
    logic [DEPTH-1:0] r_nz;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_data <= r_mem[i_raddr];
            r_flag <= r_nz[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else if (i_ctl.wr) begin
            r_nz[i_waddr] <= (i_wdata != '0);
        end
    end

    assign o_rdata = r_flag ? r_data : '0;
    assign o_nz    = r_nz;

endmodule

FILE: hdl/gpt_seq.sv
// Command sequencer: phase machine, period state, counter read-modify-write
// and the completion sweep over the counter memories. Depends on gpt_pkg.
module gpt_seq #(
    parameter int MAX_CPUS    = 16,
    parameter int COUNT_WIDTH = 16,
    parameter int AW          = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [gpt_pkg::CMD_W-1:0]         i_cmd,
    input  logic [gpt_pkg::CPU_W-1:0]         i_cpu,
    input  logic                              i_reader_active,
    input  logic [gpt_pkg::ACT_W-1:0]         i_active,
    input  logic [COUNT_WIDTH-1:0]            i_pend_rd,
    input  logic [COUNT_WIDTH-1:0]            i_done_rd,
    input  logic [MAX_CPUS-1:0]               i_pend_nz,
    output gpt_pkg::t_ram_ctl                 o_pend_ctl,
    output gpt_pkg::t_ram_ctl                 o_done_ctl,
    output logic [AW-1:0]                     o_raddr,
    output logic [AW-1:0]                     o_waddr,
    output logic [COUNT_WIDTH-1:0]            o_pend_wdata,
    output logic [COUNT_WIDTH-1:0]            o_done_wdata,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_phase,
    output logic [gpt_pkg::SEQ_W-1:0]         o_period_seq,
    output logic [gpt_pkg::MASK_OUT_W-1:0]    o_reported_mask,
    output logic                              o_period_finished,
    output logic [gpt_pkg::REL_OUT_W-1:0]     o_released_count
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_ADV   = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_RESP  = 5'b10000
    } t_state;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_state                          r_state,    n_state;
    gpt_pkg::t_phase                 r_phase,    n_phase;
    logic [gpt_pkg::SEQ_W-1:0]       r_seq,      n_seq;
    logic [MAX_CPUS-1:0]             r_owes,     n_owes;
    logic [MAX_CPUS-1:0]             r_expected, n_expected;
    logic [MAX_CPUS-1:0]             r_completed, n_completed;
    gpt_pkg::t_cmd                   r_cmd,      n_cmd;
    logic [gpt_pkg::CPU_W-1:0]       r_cpu,      n_cpu;
    logic                            r_reader,   n_reader;
    logic                            r_fin,      n_fin;
    logic [COUNT_WIDTH-1:0]          r_rel,      n_rel;
    logic [AW:0]                     r_idx,      n_idx;
    logic [AW-1:0]                   r_widx,     n_widx;
    logic                            r_wv,       n_wv;
    logic                            r_ovalid,   n_ovalid;
    logic [1:0]                      r_ophase;
    logic [gpt_pkg::SEQ_W-1:0]       r_oseq;
    logic [gpt_pkg::MASK_OUT_W-1:0]  r_omask;
    logic                            r_ofin;
    logic [gpt_pkg::REL_OUT_W-1:0]   r_orel;
    logic                            load_out;

    logic [gpt_pkg::ACT_W-1:0]       live_n;
    logic [MAX_CPUS-1:0]             live_mask;
    logic [MAX_CPUS-1:0]             cpu_bit;
    logic                            cpu_live;
    logic                            idx_live;
    logic [COUNT_WIDTH:0]            sum;
    logic [COUNT_WIDTH-1:0]          sum_sat;

    assign live_n   = (32'(i_active) > MAX_CPUS) ? gpt_pkg::ACT_W'(MAX_CPUS) : i_active;
    assign cpu_live = ({1'b0, r_cpu} < live_n);
    assign idx_live = (32'(r_idx) < 32'(live_n));
    assign sum      = {1'b0, i_done_rd} + {1'b0, i_pend_rd};
    assign sum_sat  = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];

    always_comb begin
        for (int i = 0; i < MAX_CPUS; i++) begin
            live_mask[i] = (i < 32'(live_n));
            cpu_bit[i]   = (i == 32'(r_cpu));
        end
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_seq        = r_seq;
        n_owes       = r_owes;
        n_expected   = r_expected;
        n_completed  = r_completed;
        n_cmd        = r_cmd;
        n_cpu        = r_cpu;
        n_reader     = r_reader;
        n_fin        = r_fin;
        n_rel        = r_rel;
        n_idx        = r_idx;
        n_widx       = r_widx;
        n_wv         = r_wv;
        n_ovalid     = r_ovalid & ~i_ready;
        load_out     = 1'b0;
        o_pend_ctl   = '0;
        o_done_ctl   = '0;
        o_raddr      = AW'(i_cpu);
        o_waddr      = AW'(r_cpu);
        o_pend_wdata = i_pend_rd + COUNT_WIDTH'(1);
        o_done_wdata = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd         = gpt_pkg::t_cmd'(i_cmd);
                    n_cpu         = i_cpu;
                    n_reader      = i_reader_active;
                    n_fin         = 1'b0;
                    n_rel         = '0;
                    o_pend_ctl.rd = (i_cmd == gpt_pkg::CMD_ENQ);
                    o_done_ctl.rd = (i_cmd == gpt_pkg::CMD_REL);
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd)
                    gpt_pkg::CMD_NOTE: begin
                        if (cpu_live && !r_reader && ((r_owes & cpu_bit) != '0)) begin
                            n_owes      = r_owes & ~cpu_bit;
                            n_completed = r_completed | cpu_bit;
                        end
                        n_state = ST_RESP;
                    end
                    gpt_pkg::CMD_ENQ: begin
                        o_pend_ctl.wr = cpu_live && (i_pend_rd != COUNT_MAX);
                        n_state       = ST_ADV;
                    end
                    gpt_pkg::CMD_REL: begin
                        if (cpu_live) begin
                            n_rel         = i_done_rd;
                            o_done_ctl.wr = 1'b1;
                        end
                        n_state = ST_RESP;
                    end
                    gpt_pkg::CMD_ADV: begin
                        n_state = ST_ADV;
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_ADV: begin
                n_state = ST_RESP;
                case (r_phase)
                    gpt_pkg::PH_IDLE: begin
                        if ((i_pend_nz & live_mask) != '0) begin
                            n_seq       = r_seq + 32'd1;
                            n_expected  = live_mask;
                            n_owes      = live_mask;
                            n_completed = '0;
                            n_phase     = gpt_pkg::PH_WAIT;
                        end
                    end
                    gpt_pkg::PH_WAIT: begin
                        if (r_expected != '0 && r_completed == r_expected) begin
                            n_phase = gpt_pkg::PH_DONE;
                            n_fin   = 1'b1;
                            n_idx   = '0;
                            n_wv    = 1'b0;
                            n_state = ST_SWEEP;
                        end
                    end
                    gpt_pkg::PH_DONE: begin
                        n_phase = gpt_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase = gpt_pkg::PH_IDLE;
                    end
                endcase
            end
            ST_SWEEP: begin
                o_raddr       = r_idx[AW-1:0];
                o_pend_ctl.rd = (32'(r_idx) < MAX_CPUS);
                o_done_ctl.rd = (32'(r_idx) < MAX_CPUS);
                o_waddr       = r_widx;
                o_pend_wdata  = '0;
                o_done_wdata  = sum_sat;
                o_pend_ctl.wr = r_wv;
                o_done_ctl.wr = r_wv;
                n_widx        = r_idx[AW-1:0];
                n_wv          = (32'(r_idx) < MAX_CPUS) && idx_live;
                n_idx         = r_idx + (AW+1)'(1);
                if (32'(r_idx) == MAX_CPUS) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_ovalid || i_ready) begin
                    load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= gpt_pkg::PH_IDLE;
            r_seq       <= '0;
            r_owes      <= '0;
            r_expected  <= '0;
            r_completed <= '0;
            r_wv        <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_owes      <= n_owes;
            r_expected  <= n_expected;
            r_completed <= n_completed;
            r_wv        <= n_wv;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cpu    <= n_cpu;
        r_reader <= n_reader;
        r_fin    <= n_fin;
        r_rel    <= n_rel;
        r_idx    <= n_idx;
        r_widx   <= n_widx;
        if (load_out) begin
            r_ophase <= r_phase;
            r_oseq   <= r_seq;
            r_omask  <= gpt_pkg::MASK_OUT_W'(r_completed);
            r_ofin   <= r_fin;
            r_orel   <= gpt_pkg::REL_OUT_W'(r_rel);
        end
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_valid           = r_ovalid;
    assign o_phase           = r_ophase;
    assign o_period_seq      = r_oseq;
    assign o_reported_mask   = r_omask;
    assign o_period_finished = r_ofin;
    assign o_released_count  = r_orel;

endmodule

FILE: hdl/grace_period_tracker_top.sv
// Flow: note and release go through exec and response; advance and enqueue through
// exec, advance and response; a completed period adds the sweep of both memories.
// Throughput: one word in flight; the next is taken once the result reaches the
// output register, which holds it while the consumer stalls.
// Reset: synchronous, active low; phase idle, all counts zero, active_cpus 16.
// Top level: APB register, sequencer and the pending and done counter memories.
module grace_period_tracker_top #(
    parameter int MAX_CPUS    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gpt_pkg::APB_AW-1:0]         paddr,
    input  logic [gpt_pkg::APB_DW-1:0]         pwdata,
    output logic [gpt_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [gpt_pkg::CMD_W-1:0]          i_cmd,
    input  logic [gpt_pkg::CPU_W-1:0]          i_cpu,
    input  logic                               i_reader_active,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_phase,
    output logic [gpt_pkg::SEQ_W-1:0]          o_period_seq,
    output logic [gpt_pkg::MASK_OUT_W-1:0]     o_reported_mask,
    output logic                               o_period_finished,
    output logic [gpt_pkg::REL_OUT_W-1:0]      o_released_count
);

    localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    logic [gpt_pkg::ACT_W-1:0] r_active;
    logic                      reg_hit;
    gpt_pkg::t_ram_ctl         pend_ctl;
    gpt_pkg::t_ram_ctl         done_ctl;
    logic [AW-1:0]             raddr;
    logic [AW-1:0]             waddr;
    logic [COUNT_WIDTH-1:0]    pend_wdata;
    logic [COUNT_WIDTH-1:0]    done_wdata;
    logic [COUNT_WIDTH-1:0]    pend_rd;
    logic [COUNT_WIDTH-1:0]    done_rd;
    logic [MAX_CPUS-1:0]       pend_nz;

    assign reg_hit = (paddr[2] == gpt_pkg::REG_ACTIVE) && (paddr[1:0] == 2'b00);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? gpt_pkg::APB_DW'(r_active) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= gpt_pkg::ACTIVE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == gpt_pkg::REG_ACTIVE) begin
            r_active <= pwdata[gpt_pkg::ACT_W-1:0];
        end
    end

    gpt_seq #(
        .MAX_CPUS    (MAX_CPUS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_cpu             (i_cpu),
        .i_reader_active   (i_reader_active),
        .i_active          (r_active),
        .i_pend_rd         (pend_rd),
        .i_done_rd         (done_rd),
        .i_pend_nz         (pend_nz),
        .o_pend_ctl        (pend_ctl),
        .o_done_ctl        (done_ctl),
        .o_raddr           (raddr),
        .o_waddr           (waddr),
        .o_pend_wdata      (pend_wdata),
        .o_done_wdata      (done_wdata),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_phase           (o_phase),
        .o_period_seq      (o_period_seq),
        .o_reported_mask   (o_reported_mask),
        .o_period_finished (o_period_finished),
        .o_released_count  (o_released_count)
    );

    gpt_cnt_ram #(
        .DEPTH (MAX_CPUS),
        .AW    (AW),
        .DW    (COUNT_WIDTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pend_ctl),
        .i_raddr (raddr),
        .i_waddr (waddr),
        .i_wdata (pend_wdata),
        .o_rdata (pend_rd),
        .o_nz    (pend_nz)
    );

    gpt_cnt_ram #(
        .DEPTH (MAX_CPUS),
        .AW    (AW),
        .DW    (COUNT_WIDTH)
    ) u_done_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (done_ctl),
        .i_raddr (raddr),
        .i_waddr (waddr),
        .i_wdata (done_wdata),
        .o_rdata (done_rd),
        .o_nz    ()
    );

    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_period_finished |-> o_phase == gpt_pkg::PH_DONE)
        else $error("finished period without done phase");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while one is in flight");

    a_fin_norel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_period_finished |-> o_released_count == '0)
        else $error("release reported together with period completion");

    a_no_dual_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend_ctl.wr && done_ctl.wr |-> !o_ready)
        else $error("sweep write while sequencer idle");

endmodule
